### sv/imt_pkg.sv
// Shared types and constants for the in-place matrix transpose unit.
`default_nettype none

package imt_pkg;

  localparam int unsigned REG_W   = 13;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned VALUE_W = 32;

  // Operation codes
  localparam logic [1:0] FUNC_LOAD      = 2'd0;
  localparam logic [1:0] FUNC_TRANSPOSE = 2'd1;
  localparam logic [1:0] FUNC_READ      = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  // Configuration register indexes
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } imt_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         status;
  } imt_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_TOTAL,
    S_CHECK,
    S_CLEAR,
    S_SCAN,
    S_SCAN_CHK,
    S_MULA,
    S_MOD,
    S_STEP,
    S_SWAP
  } imt_state_e;

endpackage

`default_nettype wire

### sv/in_place_matrix_transpose_unit.sv
// Top level: element store with load, read and in-place cycle-following transpose.
// Loads, undefined and out-of-range commands raise done_o in the next cycle, 1 per cycle;
// an in-range read raises it via S_READ and done_q and holds busy_o 1 cycle, so the next command waits.
// Transpose, T = rows*cols, follows the permutation cycles of the T elements, with
// P = 13 + max(13, log2(MAX_ELEMENTS)) (26 by default) bit-serial remainder steps per index.
// Reset (rst_ni low, async): idle, both sizes 1, no pending result; the receiver cannot stall.
`default_nettype none

module in_place_matrix_transpose_unit #(
  parameter int unsigned MAX_ELEMENTS  = 4096,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command channel
  input  wire logic                           start_i,
  input  wire imt_pkg::imt_cmd_t              cmd_i,
  output logic                                busy_o,
  // result channel
  output logic                                done_o,
  output imt_pkg::imt_res_t                   res_o,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [imt_pkg::REG_W-1:0]      cfg_wdata_i
);

  import imt_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ELEMENTS);
  localparam int unsigned OpW   = (AddrW > REG_W) ? AddrW : REG_W;
  localparam int unsigned ProdW = REG_W + OpW;
  localparam int unsigned StepW = $clog2(ProdW);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= REG_W'(1);
      cols_q <= REG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_COUNT: rows_q <= cfg_wdata_i;
        REG_COL_COUNT: cols_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  imt_state_e state_q, state_d;

  logic [ProdW-1:0]         prod_q;   // shared product; shifted out MSB first by the remainder
  logic [AddrW-1:0]         rem_q;    // running remainder
  logic [StepW-1:0]         step_q;   // remainder bit counter
  logic [AddrW-1:0]         last_q;   // total - 1, the modulus
  logic [AddrW-1:0]         c_q;      // cycle leader, also the clear sweep pointer
  logic [AddrW-1:0]         a_q;      // current position along a cycle
  logic [ELEMENT_WIDTH-1:0] h_q;      // element carried along the cycle (true value at c)

  // Element store and visited map: one write and one registered read per cycle each
  logic [ELEMENT_WIDTH-1:0] mem_q [MAX_ELEMENTS];
  logic [ELEMENT_WIDTH-1:0] mem_rdata_q;
  logic                     vis_q [MAX_ELEMENTS];
  logic                     vis_rdata_q;

  logic                     done_q;
  imt_res_t                 res_q;

  // ---------------------------------------------------------------------------
  // Shared arithmetic: one multiplier and one compare/subtract remainder step
  // ---------------------------------------------------------------------------
  logic [OpW-1:0]   mul_b;
  logic [ProdW-1:0] mul_p;
  logic [AddrW:0]   rem_shift;
  logic             rem_ge;
  logic [AddrW-1:0] rem_next;

  // In the total step multiply the two size registers, else rows by the cycle position
  assign mul_b     = (state_q == S_TOTAL) ? OpW'(cols_q) : OpW'(a_q);
  assign mul_p     = ProdW'(rows_q) * ProdW'(mul_b);
  assign rem_shift = {rem_q, prod_q[ProdW-1]};
  assign rem_ge    = rem_shift >= {1'b0, last_q};
  assign rem_next  = rem_ge ? AddrW'(rem_shift - {1'b0, last_q}) : AddrW'(rem_shift);

  // ---------------------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------------------
  logic accept;
  logic idx_ok;
  logic a_eq_c;
  logic c_last;
  logic a_last;
  logic too_large;
  logic trivial;

  assign accept    = start_i && !busy_o;
  assign idx_ok    = 32'(cmd_i.index) < 32'(MAX_ELEMENTS);
  assign a_eq_c    = (a_q == c_q);
  assign c_last    = (c_q == last_q);
  assign a_last    = (a_q == last_q);
  assign too_large = prod_q > ProdW'(MAX_ELEMENTS);
  assign trivial   = prod_q < ProdW'(2);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.func == FUNC_READ && idx_ok) begin
            state_d = S_READ;
          end else if (cmd_i.func == FUNC_TRANSPOSE) begin
            state_d = S_TOTAL;
          end
        end
      end
      S_READ:  state_d = S_IDLE;
      S_TOTAL: state_d = S_CHECK;
      S_CHECK: state_d = (too_large || trivial) ? S_IDLE : S_CLEAR;
      S_CLEAR: begin
        if (c_last) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (!vis_rdata_q) begin
          state_d = S_MULA;
        end else begin
          state_d = c_last ? S_IDLE : S_SCAN;
        end
      end
      // The last index is a fixed point: skip the arithmetic there
      S_MULA: state_d = a_last ? S_STEP : S_MOD;
      S_MOD: begin
        if (step_q == '0) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (!a_eq_c) begin
          state_d = S_SWAP;
        end else begin
          state_d = c_last ? S_IDLE : S_SCAN;
        end
      end
      S_SWAP:  state_d = S_MULA;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: memory ports and result strobe
  // ---------------------------------------------------------------------------
  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic [AddrW-1:0]         mem_raddr;
  logic                     vis_we;
  logic [AddrW-1:0]         vis_waddr;
  logic                     vis_wdata;
  logic                     resp_vld;
  imt_res_t                 resp;

  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = a_q;
    mem_wdata       = h_q;
    mem_raddr       = c_q;
    vis_we          = 1'b0;
    vis_waddr       = a_q;
    vis_wdata       = 1'b1;
    resp_vld        = 1'b0;
    resp.read_value = '0;
    resp.status     = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        mem_raddr = AddrW'(cmd_i.index);
        mem_waddr = AddrW'(cmd_i.index);
        mem_wdata = ELEMENT_WIDTH'(cmd_i.value);
        if (accept) begin
          case (cmd_i.func)
            FUNC_LOAD: begin
              resp_vld    = 1'b1;
              mem_we      = idx_ok;
              resp.status = idx_ok ? ST_OK : ST_RANGE;
            end
            FUNC_READ: begin
              // In-range reads answer from S_READ
              resp_vld    = !idx_ok;
              resp.status = ST_RANGE;
            end
            FUNC_TRANSPOSE: ;
            default: resp_vld = 1'b1;
          endcase
        end
      end
      S_READ: begin
        resp_vld        = 1'b1;
        resp.read_value = VALUE_W'(mem_rdata_q);
      end
      S_CHECK: begin
        resp_vld    = too_large || trivial;
        resp.status = too_large ? ST_TOO_LARGE : ST_OK;
      end
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = c_q;
        vis_wdata = 1'b0;
      end
      S_SCAN_CHK: resp_vld = vis_rdata_q && c_last;
      S_STEP: begin
        mem_raddr = a_q;
        if (a_eq_c) begin
          // Close the cycle: the carried element lands on the leader
          mem_we   = 1'b1;
          vis_we   = 1'b1;
          resp_vld = c_last;
        end
      end
      S_SWAP: begin
        mem_we = 1'b1;
        vis_we = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_q[vis_waddr] <= vis_wdata;
    end
    vis_rdata_q <= vis_q[c_q];
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_TOTAL: prod_q <= mul_p;
      S_CHECK: begin
        last_q <= AddrW'(prod_q - ProdW'(1));
        c_q    <= '0;
      end
      S_CLEAR: c_q <= c_last ? AddrW'(1) : c_q + AddrW'(1);
      S_SCAN_CHK: begin
        if (vis_rdata_q) begin
          c_q <= c_q + AddrW'(1);
        end else begin
          h_q <= mem_rdata_q;
          a_q <= c_q;
        end
      end
      S_MULA: begin
        prod_q <= mul_p;
        rem_q  <= '0;
        step_q <= StepW'(ProdW - 1);
      end
      S_MOD: begin
        rem_q  <= rem_next;
        prod_q <= prod_q << 1;
        step_q <= step_q - StepW'(1);
        if (step_q == '0) begin
          a_q <= rem_next;
        end
      end
      S_STEP: begin
        if (a_eq_c) begin
          c_q <= c_q + AddrW'(1);
        end
      end
      S_SWAP: h_q <= mem_rdata_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register: one strobe per transaction
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= resp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_vld) begin
      res_q <= resp;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> done_o)
    else $error("read did not answer in the following cycle");

  a_idle_write_is_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_IDLE) |-> (start_i && cmd_i.func == FUNC_LOAD))
    else $error("store written in idle without a load");

  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> rem_q < last_q)
    else $error("remainder reached the modulus");

  a_transpose_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.func == FUNC_TRANSPOSE) |=> (busy_o && !done_o))
    else $error("transpose did not hold busy");

  a_status_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ST_OK) |-> res_o.read_value == '0)
    else $error("error status with nonzero read data");

endmodule

`default_nettype wire

### tb/in_place_matrix_transpose_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the in-place matrix transpose unit: load, read, transpose.
module in_place_matrix_transpose_unit_tb;
  import imt_pkg::*;

  localparam int unsigned MAX_ELEMS     = 4096;
  localparam int unsigned ITEM_TARGET   = 850;
  localparam int unsigned QUIET_TAIL    = 100;     // last items go out with no sender gaps
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_PRINTS    = 40;
  // A 64x64 transpose runs with no transaction until it ends; the limit leaves it ample room.
  localparam int unsigned STALL_LIMIT   = 400000;
  // Undefined operation code: the unit answers it like a no-op.
  localparam logic [1:0]  FUNC_UNDEF    = 2'd3;

  // ------------------------------------------------------------------
  // DUT signals. Every input starts at a known value.
  // ------------------------------------------------------------------
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  imt_cmd_t         cmd_i       = '0;
  logic             busy_o;
  logic             done_o;
  imt_res_t         res_o;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = 1'b0;
  logic [REG_W-1:0] cfg_wdata_i = '0;

  in_place_matrix_transpose_unit #(
    .MAX_ELEMENTS (MAX_ELEMS),
    .ELEMENT_WIDTH(VALUE_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // Matrix model: element store, which entries hold loaded data, and the
  // size registers as last written.
  // ------------------------------------------------------------------
  logic [VALUE_W-1:0] elem_mem   [MAX_ELEMS];
  bit                 elem_known [MAX_ELEMS];
  bit                 cycle_mark [MAX_ELEMS];
  logic [REG_W-1:0]   row_cfg = 13'd1;
  logic [REG_W-1:0]   col_cfg = 13'd1;

  // Stimulus side view of which entries may be read. It runs ahead of the
  // model and is conservative: a transpose over a partly loaded region
  // makes the whole region unreadable until it is resynced at an idle point.
  bit                 gen_known  [MAX_ELEMS];

  imt_cmd_t    pending_cmds[$];
  imt_res_t    awaited_responses[$];
  imt_res_t    awaited;
  imt_res_t    fresh;
  bit          cmd_taken    = 1'b0;
  bit          sender_idles = 1'b1;
  int unsigned gap_left;
  int unsigned stall_cycles;
  int unsigned items_queued;
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned load_count;
  int unsigned read_count;
  int unsigned transpose_count;
  int unsigned too_large_count;
  int unsigned undef_count;
  int unsigned largest_matrix;

  // Rearrange the store by following permutation cycles: the element at a
  // goes to rows*a mod (total-1), the last index stays put. Loaded-ness
  // travels with the data so later reads stay legal.
  function automatic logic [1:0] permute_to_transposed();
    longint unsigned rows, total, last, a, c;
    logic [VALUE_W-1:0] tmp_word;
    bit tmp_known;
    rows  = row_cfg;
    total = rows * col_cfg;
    if (total > MAX_ELEMS) return ST_TOO_LARGE;
    for (int i = 0; i < MAX_ELEMS; i++) cycle_mark[i] = 1'b0;
    if (total < 2) return ST_OK;
    last = total - 1;
    for (c = 1; c < total; c++) begin
      if (cycle_mark[c]) continue;
      a = c;
      do begin
        a = (a == last) ? last : (rows * a) % last;
        tmp_word      = elem_mem[a];
        elem_mem[a]   = elem_mem[c];
        elem_mem[c]   = tmp_word;
        tmp_known     = elem_known[a];
        elem_known[a] = elem_known[c];
        elem_known[c] = tmp_known;
        cycle_mark[a] = 1'b1;
      end while (a != c);
    end
    return ST_OK;
  endfunction

  // Apply one accepted command to the model and return its response.
  function automatic imt_res_t compute_response(input imt_cmd_t c);
    imt_res_t r;
    r = '0;
    case (c.func)
      FUNC_LOAD: begin
        if (c.index >= MAX_ELEMS) begin
          r.status = ST_RANGE;
        end else begin
          elem_mem[c.index]   = c.value;
          elem_known[c.index] = 1'b1;
        end
      end
      FUNC_TRANSPOSE: r.status = permute_to_transposed();
      FUNC_READ: begin
        if (c.index >= MAX_ELEMS) r.status = ST_RANGE;
        else r.read_value = elem_mem[c.index];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // ------------------------------------------------------------------
  // Driver: change inputs on the falling edge. Hold start_i until the
  // transaction is taken, then advance to the next pending command or
  // insert a random idle burst.
  // ------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || cmd_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd_i   <= pending_cmds.pop_front();
        start_i <= 1'b1;
        if (sender_idles && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 12);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: sample on the rising edge. Check each done strobe against
  // the oldest awaited response first, then predict any command taken
  // at this edge.
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= start_i && !busy_o;
      if (done_o) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding: value %h status %0d",
                                    res_o.read_value, res_o.status));
        end else begin
          awaited = awaited_responses.pop_front();
          checked_count++;
          if (res_o.read_value !== awaited.read_value)
            report_mismatch($sformatf("read_value %h, predicted %h",
                                      res_o.read_value, awaited.read_value));
          if (res_o.status !== awaited.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      res_o.status, awaited.status));
        end
      end
      if (start_i && !busy_o) begin
        fresh = compute_response(cmd_i);
        awaited_responses.insert(awaited_responses.size(), fresh);
        case (cmd_i.func)
          FUNC_LOAD: load_count++;
          FUNC_READ: read_count++;
          FUNC_TRANSPOSE: begin
            transpose_count++;
            if (fresh.status == ST_TOO_LARGE) too_large_count++;
            else if (32'(row_cfg) * 32'(col_cfg) > largest_matrix)
              largest_matrix = 32'(row_cfg) * 32'(col_cfg);
          end
          default: undef_count++;
        endcase
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
               STALL_LIMIT, awaited_responses.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Queue one command and keep the readable-entry view up to date.
  task automatic queue_cmd(input logic [1:0] func, input int unsigned index,
                           input logic [VALUE_W-1:0] value);
    imt_cmd_t c;
    longint unsigned total;
    bit whole;
    c.func  = func;
    c.index = INDEX_W'(index);
    c.value = value;
    pending_cmds.insert(pending_cmds.size(), c);
    if (func != FUNC_UNDEF) items_queued++;
    if (func == FUNC_LOAD) begin
      gen_known[c.index] = 1'b1;
    end else if (func == FUNC_TRANSPOSE) begin
      total = longint'(row_cfg) * col_cfg;
      if (total >= 2 && total <= MAX_ELEMS) begin
        whole = 1'b1;
        for (int i = 0; i < total; i++) whole &= gen_known[i];
        if (!whole) for (int i = 0; i < total; i++) gen_known[i] = 1'b0;
      end
    end
  endtask

  // Read a loaded entry, preferably inside [lo, lo+span); fall back to any
  // loaded entry, and load one first if none exists.
  task automatic queue_read_known(input int unsigned lo, input int unsigned span);
    int unsigned start, idx;
    bit found;
    found = 1'b0;
    idx   = lo;
    start = $urandom_range(0, span - 1);
    for (int k = 0; k < span + MAX_ELEMS && !found; k++) begin
      idx   = (k < span) ? lo + (start + k) % span : k - span;
      found = gen_known[idx];
    end
    if (!found) begin
      idx = lo;
      queue_cmd(FUNC_LOAD, idx, rand_word());
    end
    queue_cmd(FUNC_READ, idx, $urandom);
  endtask

  // Wait until every command is taken and every response is in, then
  // resync the readable-entry view with the model.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start_i || awaited_responses.size() != 0 || busy_o);
    @(posedge clk_i);
    gen_known = elem_known;
  endtask

  task automatic write_size(input logic which, input logic [REG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= which;
    cfg_wdata_i <= val;
    if (which == REG_ROW_COUNT) row_cfg = val;
    else col_cfg = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(input int unsigned rows, input int unsigned cols);
    write_size(REG_ROW_COUNT, REG_W'(rows));
    write_size(REG_COL_COUNT, REG_W'(cols));
  endtask

  // Large matrix: scattered loads, one long transpose, then reads of
  // whatever holds loaded data afterwards.
  task automatic run_large(input int unsigned rows, input int unsigned cols);
    wait_idle();
    set_size(rows, cols);
    for (int k = 0; k < 24; k++)
      queue_cmd(FUNC_LOAD, $urandom_range(0, MAX_ELEMS - 1), rand_word());
    queue_cmd(FUNC_LOAD, MAX_ELEMS - 1, rand_word());
    queue_cmd(FUNC_TRANSPOSE, $urandom_range(0, MAX_ELEMS - 1), $urandom);
    wait_idle();
    for (int k = 0; k < 12; k++) queue_read_known(0, MAX_ELEMS);
  endtask

  // One random phase: mostly a well-formed load / transpose / read-back
  // sequence on a small matrix, sprinkled with noise and sometimes broken.
  task automatic run_phase(input bit allow_idle);
    int unsigned rows, cols, kind, region, off, n;
    bit partial;
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      rows = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      cols = (rows == 0) ? $urandom_range(0, 8) : 0;
    end else if (kind == 1) begin
      rows = $urandom_range(65, 8191);
      cols = $urandom_range(64, 8191);
    end else if (kind == 2) begin
      rows = $urandom_range(0, 1) ? 1 : $urandom_range(2, 32);
      cols = (rows == 1) ? $urandom_range(2, 32) : 1;
    end else begin
      rows = $urandom_range(1, 8);
      cols = $urandom_range(1, 8);
    end
    region  = (rows * cols >= 1 && rows * cols <= MAX_ELEMS) ? rows * cols : 8;
    partial = ($urandom_range(0, 5) == 0);

    wait_idle();
    sender_idles = allow_idle && ($urandom_range(0, 3) != 0);
    set_size(rows, cols);

    off = $urandom_range(0, region - 1);
    for (int i = 0; i < region; i++) begin
      if (!partial || $urandom_range(0, 1))
        queue_cmd(FUNC_LOAD, (i + off) % region, rand_word());
      if ($urandom_range(0, 9) == 0) queue_cmd(FUNC_UNDEF, $urandom_range(0, 4095), $urandom);
      if ($urandom_range(0, 11) == 0)
        queue_cmd(FUNC_LOAD, $urandom_range(0, MAX_ELEMS - 1), rand_word());
    end
    // Sometimes hold the sender until the unit has drained everything.
    if ($urandom_range(0, 3) == 0) wait_idle();
    queue_cmd(FUNC_TRANSPOSE, $urandom_range(0, 4095), $urandom);

    n = $urandom_range(region / 2, region) + 1;
    for (int i = 0; i < n; i++) begin
      queue_read_known(0, region);
      if ($urandom_range(0, 9) == 0) queue_cmd(FUNC_UNDEF, $urandom_range(0, 4095), $urandom);
    end
    if ($urandom_range(0, 1)) begin
      queue_cmd(FUNC_TRANSPOSE, $urandom_range(0, 4095), $urandom);
      for (int i = 0; i < 4; i++) queue_read_known(0, region);
    end
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset sizes give a single-element matrix, so transpose is a no-op.
    queue_cmd(FUNC_TRANSPOSE, 0, '0);
    queue_cmd(FUNC_UNDEF, $urandom_range(0, 4095), $urandom);
    queue_cmd(FUNC_LOAD, 0, '0);
    queue_cmd(FUNC_LOAD, MAX_ELEMS - 1, '1);
    queue_cmd(FUNC_READ, MAX_ELEMS - 1, '0);
    queue_cmd(FUNC_READ, 0, '1);
    // 2x3 matrix: load, transpose, read all six back.
    wait_idle();
    set_size(2, 3);
    for (int i = 0; i < 6; i++) queue_cmd(FUNC_LOAD, i, rand_word());
    queue_cmd(FUNC_TRANSPOSE, 0, '0);
    for (int i = 0; i < 6; i++) queue_cmd(FUNC_READ, i, '0);
    // Empty matrix, zero rows then zero columns: transpose answers ok.
    wait_idle();
    set_size(0, 3);
    queue_cmd(FUNC_TRANSPOSE, 0, '0);
    wait_idle();
    set_size(3, 0);
    queue_cmd(FUNC_TRANSPOSE, 0, '0);
    // Both registers all ones: matrix too large, store untouched.
    wait_idle();
    set_size(8191, 8191);
    queue_cmd(FUNC_TRANSPOSE, 0, '0);
    queue_cmd(FUNC_READ, 5, '0);

    // Full-store transposes: square and a single column.
    run_large(64, 64);
    run_large(4096, 1);

    while (items_queued < ITEM_TARGET - QUIET_TAIL) run_phase(1'b1);
    sender_idles = 1'b0;
    while (items_queued < ITEM_TARGET) run_phase(1'b0);

    // Drain, then give the unit time to show any stray strobe.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d loads, %0d reads, %0d transposes (%0d too large), %0d undefined ops",
             load_count, read_count, transpose_count, too_large_count, undef_count);
    $display("checked %0d responses, largest matrix transposed %0d elements, %0d mismatches",
             checked_count, largest_matrix, error_count);
    if (error_count == 0 && awaited_responses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
